/* src/rfcs_pkg.sv */
// Shared types and constants for the register frame tx/rx checksum unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package rfcs_pkg;

	localparam logic [7:0]  SYNC_BYTE    = 8'hA5;
	localparam logic [15:0] TWO_BYTE_MIN = 16'h00FF;
	localparam int          MAX_WORDS    = 5;
	localparam int          S_TDATA_W    = 40;
	localparam int          M_TDATA_W    = 48;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_RX_BYTE = 2'd2,
		OP_TIMEOUT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_SUM = 2'd1,
		ST_NO_DATA = 2'd2
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  reg_addr;
		logic [15:0] data_word;
		logic [2:0]  read_size;
		logic [7:0]  rx_byte;
	} item_t;

	// Everything one item puts out: a run of transmit bytes or one reply word.
	typedef struct packed {
		logic                        is_reply;
		logic [2:0]                  n_words;
		logic [MAX_WORDS-1:0][7:0]   bytes;
		logic [31:0]                 value;
		status_t                     status;
	} frame_t;

endpackage
`default_nettype wire

/* src/rfcs_frame_build.sv */
// Frame builder and reply receiver: turns one item into a frame description
// and keeps the receive state. Depends on rfcs_pkg.
`default_nettype none
module rfcs_frame_build
	import rfcs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   fire,
	input  wire item_t  item,
	output frame_t      frame
);

	logic        armed_q;
	logic [2:0]  expected_q;
	logic [2:0]  count_q;
	logic [7:0]  sum_q;
	logic [31:0] value_q;
	logic [7:0]  last_byte_q;

	logic [7:0]  hdr_sum;
	logic [7:0]  one_sum;
	logic [7:0]  two_sum;
	logic [7:0]  acc_sum;
	logic [31:0] acc_val;
	logic        rx_done;

	assign hdr_sum = SYNC_BYTE + item.reg_addr;
	assign one_sum = hdr_sum + item.data_word[7:0];
	assign two_sum = one_sum + item.data_word[15:8];
	// fold the previously held byte into sum and value
	assign acc_sum = (count_q != 3'd0) ? sum_q + last_byte_q : sum_q;
	assign acc_val = (count_q != 3'd0) ? {value_q[23:0], last_byte_q} : value_q;
	assign rx_done = (count_q >= expected_q);

	always_comb begin
		frame          = '0;
		frame.bytes[0] = SYNC_BYTE;
		frame.bytes[1] = item.reg_addr;
		unique case (item.op)
			OP_WRITE: begin
				if (item.data_word == 16'd0) begin
					frame.n_words = 3'd2;
				end else if (item.data_word < TWO_BYTE_MIN) begin
					frame.n_words  = 3'd4;
					frame.bytes[2] = item.data_word[7:0];
					frame.bytes[3] = ~one_sum;
				end else begin
					frame.n_words  = 3'd5;
					frame.bytes[2] = item.data_word[15:8];
					frame.bytes[3] = item.data_word[7:0];
					frame.bytes[4] = ~two_sum;
				end
			end
			OP_READ: begin
				frame.n_words = 3'd2;
			end
			OP_RX_BYTE: begin
				if (armed_q && rx_done) begin
					frame.is_reply = 1'b1;
					frame.n_words  = 3'd1;
					if (~acc_sum == item.rx_byte) begin
						frame.status = ST_OK;
						frame.value  = acc_val;
					end else begin
						frame.status = ST_BAD_SUM;
					end
				end
			end
			OP_TIMEOUT: begin
				if (armed_q) begin
					frame.is_reply = 1'b1;
					frame.n_words  = 3'd1;
					if (count_q == 3'd0) begin
						frame.status = ST_NO_DATA;
					end else if (~sum_q == last_byte_q) begin
						frame.status = ST_OK;
						frame.value  = value_q;
					end else begin
						frame.status = ST_BAD_SUM;
					end
				end
			end
			default: frame.n_words = 3'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			expected_q  <= 3'd0;
			count_q     <= 3'd0;
			sum_q       <= 8'd0;
			value_q     <= 32'd0;
			last_byte_q <= 8'd0;
		end else if (fire) begin
			unique case (item.op)
				OP_WRITE: begin
				end
				OP_READ: begin
					armed_q     <= 1'b1;
					expected_q  <= item.read_size;
					count_q     <= 3'd0;
					sum_q       <= hdr_sum;
					value_q     <= 32'd0;
					last_byte_q <= 8'd0;
				end
				OP_RX_BYTE: begin
					if (armed_q) begin
						sum_q       <= acc_sum;
						value_q     <= acc_val;
						last_byte_q <= item.rx_byte;
						if (rx_done) begin
							armed_q <= 1'b0;
							count_q <= 3'd0;
						end else begin
							count_q <= count_q + 3'd1;
						end
					end
				end
				OP_TIMEOUT: begin
					if (armed_q) begin
						armed_q <= 1'b0;
						count_q <= 3'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/rfcs_word_out.sv */
// Output frame register: holds one built frame, hands it to the master
// stream one word per cycle while m_tready is high. Depends on rfcs_pkg.
`default_nettype none
module rfcs_word_out
	import rfcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire frame_t                frame,
	output logic                       free,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast
);

	logic       valid_q;
	frame_t     frame_q;
	logic [2:0] idx_q;
	logic       at_end;
	logic       take;

	assign at_end   = (idx_q == frame_q.n_words - 3'd1);
	assign take     = valid_q && m_tready;
	// frame register may be reloaded when empty or when its final word leaves
	assign free     = !valid_q || (take && at_end);
	assign m_tvalid = valid_q;
	assign m_tuser  = frame_q.is_reply;
	assign m_tlast  = !frame_q.is_reply && at_end;

	always_comb begin
		m_tdata = '0;
		if (frame_q.is_reply) begin
			m_tdata[39:8]  = frame_q.value;
			m_tdata[41:40] = frame_q.status;
		end else begin
			m_tdata[7:0] = frame_q.bytes[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 3'd0;
		end else if (take) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
	end

endmodule
`default_nettype wire

/* src/register_frame_tx_rx_checksum_unit.sv */
// Top level of the register frame tx/rx checksum unit.
// Depends on rfcs_pkg, rfcs_frame_build and rfcs_word_out.
`default_nettype none
// Host-side framer/deframer for a register-access serial link. Each slave
// word carries one command (tuser): write (0) emits 0xA5, the register byte,
// then nothing, one data byte (1..0xFE) or two big-endian bytes (0xFF and
// up) followed by the inverted 8-bit sum of the frame; read (1) emits 0xA5
// and the register byte and arms the receiver for read_size data bytes plus
// a checksum byte; received byte (2) feeds the receiver; timeout (3) closes a
// pending reply. Transmit bytes leave as master words with tuser 0 and tlast
// on the final byte of a frame; a finished reply leaves as one word with
// tuser 1, the big-endian value (zero unless status is ok) and a status of
// ok, checksum mismatch or nothing received. Received bytes and timeouts
// while no reply is pending produce no word. Timing: a slave word goes into
// an input register, is built into a frame combinationally and parked in the
// output frame register. The master port moves one word per cycle while
// m_tready is high; an item produces 0, 1, 2, 4 or 5 words. An item waits
// in the input register until the frame register is free, so received
// bytes stream at one per cycle only while no frame is draining.
module register_frame_tx_rx_checksum_unit
	import rfcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [7:0] reg_addr, [23:8] data_word, [26:24] read_size, [34:27] rx_byte
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// [1:0] op
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [7:0] tx_byte, [39:8] read_value, [41:40] read_status
	output logic [M_TDATA_W-1:0]       m_tdata,
	// [0] kind
	output logic                       m_tuser,
	output logic                       m_tlast
);

	logic   item_vld_s1;
	item_t  item_s1;
	logic   out_free;
	logic   fire;
	logic   load;
	frame_t frame;

	// item leaves the input register when the frame register can take it;
	// items that produce no word just update the receiver
	assign fire     = item_vld_s1 && out_free;
	assign load     = fire && (frame.n_words != 3'd0);
	assign s_tready = !item_vld_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			item_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op        <= op_t'(s_tuser);
			item_s1.reg_addr  <= s_tdata[7:0];
			item_s1.data_word <= s_tdata[23:8];
			item_s1.read_size <= s_tdata[26:24];
			item_s1.rx_byte   <= s_tdata[34:27];
		end
	end

	rfcs_frame_build u_build (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.frame  (frame)
	);

	rfcs_word_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.frame    (frame),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// a reply word is never marked as the end of a transmit frame
	a_reply_no_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast)
		else $error("reply word carries tlast");

	// value is only reported with an ok status
	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && (m_tdata[41:40] != ST_OK) |-> m_tdata[39:8] == 32'd0)
		else $error("reply value nonzero with bad status");

	// a read or write command always presents a word in the next cycle
	a_cmd_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item_s1.op == OP_READ || item_s1.op == OP_WRITE) |=> m_tvalid && !m_tuser)
		else $error("command produced no transmit word");

	// transmit bytes are never sent with a status or value
	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[41:8] == 34'd0)
		else $error("transmit word carries reply fields");

endmodule
`default_nettype wire
